// File: rtl/assert_macros.svh
// Assertion helpers used by the verification checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked during reset.
`define ASSERT_CLK_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/mre_pkg.sv
`default_nettype none

package mre_pkg;

    localparam int REG_COUNT = 32;
    localparam int MEM_WORDS = 1024;
    localparam int RF_AW     = $clog2(REG_COUNT);
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam int FUNC_W = 3;
    localparam int REG_W  = 5;
    localparam int SLOT_W = 6;
    localparam int IMM_W  = 16;
    localparam int POS_W  = 10;
    localparam int NPOS_W = 11;
    localparam int DATA_W = 32;
    localparam int CNT_W  = 16;
    localparam int CYC_W  = 18;

    localparam int unsigned PIPE_FILL = 5;

    // Slot code that stands for "no register" and never matches.
    localparam logic [SLOT_W-1:0] NO_SLOT = SLOT_W'(32);

    localparam logic [FUNC_W-1:0] F_ADD  = 3'd0;
    localparam logic [FUNC_W-1:0] F_ADDI = 3'd1;
    localparam logic [FUNC_W-1:0] F_SUB  = 3'd2;
    localparam logic [FUNC_W-1:0] F_SLT  = 3'd3;
    localparam logic [FUNC_W-1:0] F_LW   = 3'd4;
    localparam logic [FUNC_W-1:0] F_SW   = 3'd5;
    localparam logic [FUNC_W-1:0] F_BEQ  = 3'd6;
    localparam logic [FUNC_W-1:0] F_NOP  = 3'd7;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        logic [IMM_W-1:0]  imm;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  position;
    } t_alu_in;

    typedef struct packed {
        logic [DATA_W-1:0] res;
        logic              taken;
        logic [NPOS_W-1:0] next_pos;
    } t_alu_out;

endpackage

`default_nettype wire

// File: rtl/mre_alu.sv
`default_nettype none

module mre_alu (
    input  wire mre_pkg::t_alu_in  i_req,
    output mre_pkg::t_alu_out      o_rsp
);
    import mre_pkg::*;

    logic [DATA_W-1:0] imm_ext;

    assign imm_ext = {{(DATA_W-IMM_W){i_req.imm[IMM_W-1]}}, i_req.imm};

    always_comb begin
        o_rsp.res      = '0;
        o_rsp.taken    = 1'b0;
        o_rsp.next_pos = NPOS_W'(i_req.position) + NPOS_W'(1);
        case (i_req.func)
            F_ADD: begin
                o_rsp.res = i_req.va + i_req.vb;
            end
            F_ADDI: begin
                o_rsp.res = i_req.va + imm_ext;
            end
            F_SUB: begin
                o_rsp.res = i_req.va - i_req.vb;
            end
            F_SLT: begin
                o_rsp.res = DATA_W'($signed(i_req.va) < $signed(i_req.vb));
            end
            F_SW: begin
                o_rsp.res = i_req.vb;
            end
            F_BEQ: begin
                if (i_req.va == i_req.vb) begin
                    o_rsp.taken    = 1'b1;
                    o_rsp.next_pos = NPOS_W'(i_req.target);
                end
            end
            default: begin
                // Loads take their value from the data memory one stage later.
                o_rsp.res = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

// File: rtl/mini_risc_execute_with_hazard_count_unit.sv
`default_nettype none
// Channel | Dir | Handshake         | Payload
// --------+-----+-------------------+------------------------------------------------
// request | in  | i_valid / o_stall | i_func i_reg_d i_reg_a i_reg_b i_immediate
//         |     |                   | i_target i_position
// result  | out | o_valid / i_stall | o_result_value o_branch_taken o_next_position
//         |     |                   | o_hazard o_executed_total o_stall_total
//         |     |                   | o_cycles_forwarding o_cycles_stalling
//
// One transaction per cycle is taken while o_stall is low; it reaches o_valid through the stages below.
// Stages: register file read, execute plus data memory access, write-back into the
// output register. The single write port of each memory sets that rate.
// After reset the data memory is cleared, one word a cycle, all 1024 words, with o_stall high.
// A stall on the result side reaches o_stall in the same cycle once the stages are full.

module mini_risc_execute_with_hazard_count_unit (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               i_valid,
    output logic                                    o_stall,
    input  wire logic [mre_pkg::FUNC_W-1:0]         i_func,
    input  wire logic [mre_pkg::REG_W-1:0]          i_reg_d,
    input  wire logic [mre_pkg::REG_W-1:0]          i_reg_a,
    input  wire logic [mre_pkg::REG_W-1:0]          i_reg_b,
    input  wire logic signed [mre_pkg::IMM_W-1:0]   i_immediate,
    input  wire logic [mre_pkg::POS_W-1:0]          i_target,
    input  wire logic [mre_pkg::POS_W-1:0]          i_position,
    output logic                                    o_valid,
    input  wire logic                               i_stall,
    output logic signed [mre_pkg::DATA_W-1:0]       o_result_value,
    output logic                                    o_branch_taken,
    output logic [mre_pkg::NPOS_W-1:0]              o_next_position,
    output logic                                    o_hazard,
    output logic [mre_pkg::CNT_W-1:0]               o_executed_total,
    output logic [mre_pkg::CNT_W-1:0]               o_stall_total,
    output logic [mre_pkg::CYC_W-1:0]               o_cycles_forwarding,
    output logic [mre_pkg::CYC_W-1:0]               o_cycles_stalling
);
    import mre_pkg::*;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REG_W-1:0]  reg_d;
        logic [REG_W-1:0]  reg_a;
        logic [REG_W-1:0]  reg_b;
        logic [IMM_W-1:0]  imm;
        logic [POS_W-1:0]  target;
        logic [POS_W-1:0]  position;
        logic              hazard;
        logic [CNT_W-1:0]  executed;
        logic [CNT_W-1:0]  branches;
        logic [CNT_W-1:0]  stalls;
    } t_ex_item;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [REG_W-1:0]  reg_d;
        logic [DATA_W-1:0] res;
        logic              taken;
        logic [NPOS_W-1:0] next_pos;
        logic              hazard;
        logic [CNT_W-1:0]  executed;
        logic [CNT_W-1:0]  branches;
        logic [CNT_W-1:0]  stalls;
    } t_mem_item;

    typedef struct packed {
        logic [DATA_W-1:0] result_value;
        logic              branch_taken;
        logic [NPOS_W-1:0] next_position;
        logic              hazard;
        logic [CNT_W-1:0]  executed_total;
        logic [CNT_W-1:0]  stall_total;
        logic [CYC_W-1:0]  cyc_fwd;
        logic [CYC_W-1:0]  cyc_stall;
    } t_result;

    function automatic logic slot_hit(input logic [SLOT_W-1:0] s,
                                      input logic [SLOT_W-1:0] p0,
                                      input logic [SLOT_W-1:0] p1);
        return (s != NO_SLOT) && ((s == p0) || (s == p1));
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + CNT_W'(1);
    endfunction

    // Handshake and stage control.
    logic accept, out_free, mem_adv, mem_free, ex_adv, ex_free;
    logic r_clr_busy;
    logic [MEM_AW-1:0] r_clr_addr;
    logic r_ex_vld, r_mem_vld, r_out_vld;
    t_ex_item  r_ex;
    t_mem_item r_mem;
    t_result   r_out, n_out;

    // Hazard history and counters.
    logic [SLOT_W-1:0] r_prev0, r_prev1;
    logic [SLOT_W-1:0] in_wslot, in_c1, in_c2;
    logic in_hazard;
    logic [CNT_W-1:0] r_exec, r_branch, r_stalls, n_exec, n_branch, n_stalls;

    // Register file.
    logic [DATA_W-1:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] r_rf_vld;
    logic [DATA_W-1:0] r_rf_qa, r_rf_qb;
    logic [RF_AW-1:0] in_ra_idx, in_rb_idx, rf_widx;
    logic rf_we;
    logic [DATA_W-1:0] rf_wdata;
    logic r_opa_vld, r_opa_sel, r_opb_vld, r_opb_sel;
    logic [DATA_W-1:0] r_opa_ovr, r_opb_ovr;

    // Execute and data memory.
    logic mem_wr;
    logic [DATA_W-1:0] mem_val, va, vb;
    t_alu_in  alu_req;
    t_alu_out alu_rsp;
    logic [DATA_W-1:0] dm_mem [MEM_WORDS];
    logic [DATA_W-1:0] r_dm_q;
    logic [MEM_AW-1:0] dm_addr;

    assign out_free = !r_out_vld || !i_stall;
    assign mem_free = !r_mem_vld || out_free;
    assign mem_adv  = r_mem_vld && out_free;
    assign ex_free  = !r_ex_vld || mem_free;
    assign ex_adv   = r_ex_vld && mem_free;
    assign o_stall  = r_clr_busy || !ex_free;
    assign accept   = i_valid && !o_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex_vld  <= 1'b0;
            r_mem_vld <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (accept) begin
                r_ex_vld <= 1'b1;
            end else if (ex_adv) begin
                r_ex_vld <= 1'b0;
            end
            if (ex_adv) begin
                r_mem_vld <= 1'b1;
            end else if (mem_adv) begin
                r_mem_vld <= 1'b0;
            end
            if (mem_adv) begin
                r_out_vld <= 1'b1;
            end else if (!i_stall) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // Data memory clearing sweep after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == MEM_AW'(MEM_WORDS - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + MEM_AW'(1);
        end
    end

    // Written and checked slots of the incoming instruction.
    always_comb begin
        in_wslot = NO_SLOT;
        in_c1    = NO_SLOT;
        in_c2    = NO_SLOT;
        case (i_func)
            F_ADD, F_SUB, F_SLT: begin
                in_wslot = SLOT_W'(i_reg_d);
                in_c1    = SLOT_W'(i_reg_a);
                in_c2    = SLOT_W'(i_reg_b);
            end
            F_ADDI, F_LW: begin
                in_wslot = SLOT_W'(i_reg_d);
                in_c1    = SLOT_W'(i_reg_a);
            end
            F_SW, F_BEQ: begin
                in_wslot = SLOT_W'(i_reg_a);
                in_c1    = SLOT_W'(i_reg_b);
            end
            default: begin
                in_wslot = NO_SLOT;
            end
        endcase
    end

    assign in_hazard = slot_hit(in_c1, r_prev0, r_prev1) || slot_hit(in_c2, r_prev0, r_prev1);
    assign n_exec    = (i_func != F_NOP) ? sat_inc(r_exec) : r_exec;
    assign n_branch  = (i_func == F_BEQ) ? sat_inc(r_branch) : r_branch;
    assign n_stalls  = in_hazard ? sat_inc(r_stalls) : r_stalls;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev0  <= NO_SLOT;
            r_prev1  <= NO_SLOT;
            r_exec   <= '0;
            r_branch <= '0;
            r_stalls <= '0;
        end else if (accept) begin
            r_prev0  <= in_wslot;
            r_prev1  <= r_prev0;
            r_exec   <= n_exec;
            r_branch <= n_branch;
            r_stalls <= n_stalls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ex.func     <= i_func;
            r_ex.reg_d    <= i_reg_d;
            r_ex.reg_a    <= i_reg_a;
            r_ex.reg_b    <= i_reg_b;
            r_ex.imm      <= i_immediate;
            r_ex.target   <= i_target;
            r_ex.position <= i_position;
            r_ex.hazard   <= in_hazard;
            r_ex.executed <= n_exec;
            r_ex.branches <= n_branch;
            r_ex.stalls   <= n_stalls;
        end
    end

    // Register file: two registered read ports, one write port at write-back.
    assign in_ra_idx = i_reg_a[RF_AW-1:0];
    assign in_rb_idx = i_reg_b[RF_AW-1:0];
    assign mem_wr    = r_mem_vld && (r_mem.func inside {F_ADD, F_ADDI, F_SUB, F_SLT, F_LW});
    assign mem_val   = (r_mem.func == F_LW) ? r_dm_q : r_mem.res;
    assign rf_we     = mem_adv && mem_wr;
    assign rf_widx   = r_mem.reg_d[RF_AW-1:0];
    assign rf_wdata  = mem_val;

    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            rf_mem[rf_widx] <= rf_wdata;
        end
        if (accept) begin
            r_rf_qa <= rf_mem[in_ra_idx];
            r_rf_qb <= rf_mem[in_rb_idx];
        end
    end

    // Entries never written read as zero.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[rf_widx] <= 1'b1;
        end
    end

    // A write-back that lands while the operands wait in execute replaces the
    // stale read data, including one that coincides with the read itself.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_opa_vld <= r_rf_vld[in_ra_idx];
            r_opb_vld <= r_rf_vld[in_rb_idx];
            r_opa_sel <= rf_we && (rf_widx == in_ra_idx);
            r_opb_sel <= rf_we && (rf_widx == in_rb_idx);
            r_opa_ovr <= rf_wdata;
            r_opb_ovr <= rf_wdata;
        end else if (r_ex_vld && rf_we) begin
            if (rf_widx == r_ex.reg_a[RF_AW-1:0]) begin
                r_opa_sel <= 1'b1;
                r_opa_ovr <= rf_wdata;
            end
            if (rf_widx == r_ex.reg_b[RF_AW-1:0]) begin
                r_opb_sel <= 1'b1;
                r_opb_ovr <= rf_wdata;
            end
        end
    end

    // The instruction in the memory stage is the only older one not yet written back.
    always_comb begin
        if (mem_wr && (r_mem.reg_d[RF_AW-1:0] == r_ex.reg_a[RF_AW-1:0])) begin
            va = mem_val;
        end else if (r_opa_sel) begin
            va = r_opa_ovr;
        end else begin
            va = r_opa_vld ? r_rf_qa : '0;
        end
        if (mem_wr && (r_mem.reg_d[RF_AW-1:0] == r_ex.reg_b[RF_AW-1:0])) begin
            vb = mem_val;
        end else if (r_opb_sel) begin
            vb = r_opb_ovr;
        end else begin
            vb = r_opb_vld ? r_rf_qb : '0;
        end
    end

    assign alu_req.func     = r_ex.func;
    assign alu_req.va       = va;
    assign alu_req.vb       = vb;
    assign alu_req.imm      = r_ex.imm;
    assign alu_req.target   = r_ex.target;
    assign alu_req.position = r_ex.position;

    mre_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // Data memory: one port shared by the clearing sweep, stores and loads.
    assign dm_addr = va[MEM_AW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            dm_mem[r_clr_addr] <= '0;
        end else if (ex_adv && (r_ex.func == F_SW)) begin
            dm_mem[dm_addr] <= vb;
        end
        if (ex_adv && (r_ex.func == F_LW)) begin
            r_dm_q <= dm_mem[dm_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ex_adv) begin
            r_mem.func     <= r_ex.func;
            r_mem.reg_d    <= r_ex.reg_d;
            r_mem.res      <= alu_rsp.res;
            r_mem.taken    <= alu_rsp.taken;
            r_mem.next_pos <= alu_rsp.next_pos;
            r_mem.hazard   <= r_ex.hazard;
            r_mem.executed <= r_ex.executed;
            r_mem.branches <= r_ex.branches;
            r_mem.stalls   <= r_ex.stalls;
        end
    end

    always_comb begin
        n_out.result_value   = mem_val;
        n_out.branch_taken   = r_mem.taken;
        n_out.next_position  = r_mem.next_pos;
        n_out.hazard         = r_mem.hazard;
        n_out.executed_total = r_mem.executed;
        n_out.stall_total    = r_mem.stalls;
        n_out.cyc_fwd        = CYC_W'(r_mem.executed) + CYC_W'(r_mem.branches)
                             + CYC_W'(PIPE_FILL - 1);
        n_out.cyc_stall      = n_out.cyc_fwd + CYC_W'(r_mem.stalls);
    end

    always_ff @(posedge i_clk) begin
        if (mem_adv) begin
            r_out <= n_out;
        end
    end

    assign o_valid             = r_out_vld;
    assign o_result_value      = $signed(r_out.result_value);
    assign o_branch_taken      = r_out.branch_taken;
    assign o_next_position     = r_out.next_position;
    assign o_hazard            = r_out.hazard;
    assign o_executed_total    = r_out.executed_total;
    assign o_stall_total       = r_out.stall_total;
    assign o_cycles_forwarding = r_out.cyc_fwd;
    assign o_cycles_stalling   = r_out.cyc_stall;

endmodule

`default_nettype wire

// File: rtl/mre_checker.sv
`default_nettype none
`include "assert_macros.svh"

module mre_checker (
    input wire logic                        i_clk,
    input wire logic                        i_rst_n,
    input wire logic                        o_stall,
    input wire logic                        o_valid,
    input wire logic                        i_stall,
    input wire logic [mre_pkg::DATA_W-1:0]  o_result_value,
    input wire logic                        o_branch_taken,
    input wire logic                        o_hazard,
    input wire logic [mre_pkg::CNT_W-1:0]   o_stall_total,
    input wire logic [mre_pkg::CYC_W-1:0]   o_cycles_forwarding,
    input wire logic [mre_pkg::CYC_W-1:0]   o_cycles_stalling
);
    import mre_pkg::*;

    // o_cycles_stalling equals o_cycles_forwarding plus the stall count.
    `ASSERT_CLK(a_cycle_split, i_clk, i_rst_n, o_valid |-> (o_cycles_stalling == CYC_W'(o_cycles_forwarding + CYC_W'(o_stall_total))), "cycle totals disagree with stall count")

    // A flagged hazard has been counted, and the count saturates instead of wrapping.
    `ASSERT_CLK(a_hazard_counted, i_clk, i_rst_n, (o_valid && o_hazard) |-> (o_stall_total != '0), "hazard flagged but stall count is zero")

    // A taken branch writes nothing and reports a zero value.
    `ASSERT_CLK(a_taken_zero, i_clk, i_rst_n, (o_valid && o_branch_taken) |-> (o_result_value == '0), "taken branch with nonzero value")

    // Leaving reset starts the memory clearing sweep, which holds off requests.
    `ASSERT_CLK_NORST(a_clear_after_reset, i_clk, !i_rst_n |=> o_stall, "request side open right after reset")

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, (o_valid && i_stall) |=> (o_valid && $stable(o_result_value)), "stalled result changed")

endmodule

bind mini_risc_execute_with_hazard_count_unit mre_checker u_mre_checker (
    .i_clk               (i_clk),
    .i_rst_n             (i_rst_n),
    .o_stall             (o_stall),
    .o_valid             (o_valid),
    .i_stall             (i_stall),
    .o_result_value      (o_result_value),
    .o_branch_taken      (o_branch_taken),
    .o_hazard            (o_hazard),
    .o_stall_total       (o_stall_total),
    .o_cycles_forwarding (o_cycles_forwarding),
    .o_cycles_stalling   (o_cycles_stalling)
);

`default_nettype wire

// File: tb/sv/testbench.sv
`default_nettype none

module testbench;
    import mre_pkg::*;

    localparam int RANDOM_ITEMS = 1000;
    // A closing run of back-to-back branches, each depending on the one before it.
    localparam int SAT_ITEMS    = 80;
    localparam int HOLD_AT      = 400;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [FUNC_W-1:0]       func;
        logic [REG_W-1:0]        rd;
        logic [REG_W-1:0]        ra;
        logic [REG_W-1:0]        rb;
        logic signed [IMM_W-1:0] imm;
        logic [POS_W-1:0]        tgt;
        logic [POS_W-1:0]        pos;
        logic                    lit;
        logic [DATA_W-1:0]       lit_value;
        logic                    lit_taken;
        logic [NPOS_W-1:0]       lit_next;
    } instr_row_t;

    typedef struct packed {
        logic [DATA_W-1:0] value;
        logic              taken;
        logic [NPOS_W-1:0] next_pos;
        logic              hazard;
        logic [CNT_W-1:0]  executed;
        logic [CNT_W-1:0]  stalls;
        logic [CYC_W-1:0]  cyc_fwd;
        logic [CYC_W-1:0]  cyc_stall;
    } exec_result_t;

    // Rows with lit set carry the value, taken flag and next position in the table.
    localparam instr_row_t DIRECTED [19] = '{
        '{F_ADD,  5'd1,  5'd0,  5'd0,  16'sd0,    10'd0,    10'd0,    1'b1, 32'd0,        1'b0, 11'd1},
        '{F_ADDI, 5'd1,  5'd0,  5'd0,  16'sh7FFF, 10'd0,    10'd1023, 1'b1, 32'd32767,    1'b0, 11'd1024},
        '{F_ADDI, 5'd2,  5'd0,  5'd0,  16'sh8000, 10'd0,    10'd2,    1'b1, 32'hFFFF8000, 1'b0, 11'd3},
        '{F_ADD,  5'd3,  5'd1,  5'd2,  16'sd0,    10'd0,    10'd3,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_SLT,  5'd4,  5'd3,  5'd1,  16'sd0,    10'd0,    10'd4,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_SLT,  5'd5,  5'd1,  5'd3,  16'sd0,    10'd0,    10'd5,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_SUB,  5'd6,  5'd0,  5'd3,  16'sd0,    10'd0,    10'd6,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_NOP,  5'd31, 5'd31, 5'd31, 16'shFFFF, 10'd1023, 10'd1023, 1'b1, 32'd0,        1'b0, 11'd1024},
        '{F_SW,   5'd0,  5'd5,  5'd3,  16'sd0,    10'd0,    10'd8,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_LW,   5'd9,  5'd0,  5'd0,  16'sd0,    10'd0,    10'd9,    1'b0, 32'd0,        1'b0, 11'd0},
        '{F_LW,   5'd10, 5'd1,  5'd0,  16'sd0,    10'd0,    10'd10,   1'b1, 32'd0,        1'b0, 11'd11},
        '{F_SW,   5'd0,  5'd2,  5'd1,  16'sd0,    10'd0,    10'd11,   1'b0, 32'd0,        1'b0, 11'd0},
        '{F_BEQ,  5'd0,  5'd0,  5'd5,  16'sd0,    10'd1023, 10'd12,   1'b1, 32'd0,        1'b1, 11'd1023},
        '{F_BEQ,  5'd0,  5'd1,  5'd2,  16'sd0,    10'd500,  10'd1023, 1'b1, 32'd0,        1'b0, 11'd1024},
        '{F_BEQ,  5'd0,  5'd31, 5'd31, 16'sd0,    10'd0,    10'd14,   1'b1, 32'd0,        1'b1, 11'd0},
        '{F_ADDI, 5'd0,  5'd0,  5'd0,  16'shFFFF, 10'd0,    10'd15,   1'b1, 32'hFFFFFFFF, 1'b0, 11'd16},
        '{F_ADD,  5'd31, 5'd0,  5'd0,  16'sd0,    10'd0,    10'd16,   1'b0, 32'd0,        1'b0, 11'd0},
        '{F_LW,   5'd11, 5'd3,  5'd0,  16'sd0,    10'd0,    10'd17,   1'b0, 32'd0,        1'b0, 11'd0},
        '{F_SLT,  5'd12, 5'd2,  5'd3,  16'sd0,    10'd0,    10'd18,   1'b0, 32'd0,        1'b0, 11'd0}
    };

    logic                    i_clk = 1'b0;
    logic                    i_rst_n;
    logic                    i_valid;
    logic                    o_stall;
    logic [FUNC_W-1:0]       i_func;
    logic [REG_W-1:0]        i_reg_d;
    logic [REG_W-1:0]        i_reg_a;
    logic [REG_W-1:0]        i_reg_b;
    logic signed [IMM_W-1:0] i_immediate;
    logic [POS_W-1:0]        i_target;
    logic [POS_W-1:0]        i_position;
    logic                    o_valid;
    logic                    i_stall;
    logic signed [DATA_W-1:0] o_result_value;
    logic                    o_branch_taken;
    logic [NPOS_W-1:0]       o_next_position;
    logic                    o_hazard;
    logic [CNT_W-1:0]        o_executed_total;
    logic [CNT_W-1:0]        o_stall_total;
    logic [CYC_W-1:0]        o_cycles_forwarding;
    logic [CYC_W-1:0]        o_cycles_stalling;

    // Shadow copy of the architectural state.
    logic [DATA_W-1:0] reg_model [REG_COUNT];
    logic [DATA_W-1:0] mem_model [MEM_WORDS];
    logic [SLOT_W-1:0] last_wslot [2];
    logic [CNT_W-1:0]  exec_cnt;
    logic [CNT_W-1:0]  branch_cnt;
    logic [CNT_W-1:0]  hazard_cnt;

    exec_result_t pending_results [$];
    int           mismatch_count = 0;
    int           results_seen = 0;
    bit           fast_mode = 1'b0;

    always #5 i_clk = ~i_clk;

    mini_risc_execute_with_hazard_count_unit dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_func              (i_func),
        .i_reg_d             (i_reg_d),
        .i_reg_a             (i_reg_a),
        .i_reg_b             (i_reg_b),
        .i_immediate         (i_immediate),
        .i_target            (i_target),
        .i_position          (i_position),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_result_value      (o_result_value),
        .o_branch_taken      (o_branch_taken),
        .o_next_position     (o_next_position),
        .o_hazard            (o_hazard),
        .o_executed_total    (o_executed_total),
        .o_stall_total       (o_stall_total),
        .o_cycles_forwarding (o_cycles_forwarding),
        .o_cycles_stalling   (o_cycles_stalling)
    );

    function automatic bit slot_hit(logic [SLOT_W-1:0] s);
        return s != NO_SLOT && (s == last_wslot[0] || s == last_wslot[1]);
    endfunction

    function automatic logic [CNT_W-1:0] sat_inc(logic [CNT_W-1:0] c);
        return (c == '1) ? c : c + 1'b1;
    endfunction

    function automatic exec_result_t execute_instr(instr_row_t ins);
        exec_result_t      r;
        logic [DATA_W-1:0] va;
        logic [DATA_W-1:0] vb;
        logic [DATA_W-1:0] imm32;
        logic [SLOT_W-1:0] wslot;
        logic [SLOT_W-1:0] c1;
        logic [SLOT_W-1:0] c2;
        va = reg_model[ins.ra];
        vb = reg_model[ins.rb];
        imm32 = {{(DATA_W-IMM_W){ins.imm[IMM_W-1]}}, ins.imm};
        r = '0;
        r.next_pos = {1'b0, ins.pos} + 1'b1;
        wslot = NO_SLOT;
        c1 = NO_SLOT;
        c2 = NO_SLOT;
        case (ins.func)
            F_ADD, F_SUB, F_SLT: begin
                if (ins.func == F_ADD)
                    r.value = va + vb;
                else if (ins.func == F_SUB)
                    r.value = va - vb;
                else
                    r.value = ($signed(va) < $signed(vb)) ? 32'd1 : 32'd0;
                reg_model[ins.rd] = r.value;
                wslot = {1'b0, ins.rd};
                c1 = {1'b0, ins.ra};
                c2 = {1'b0, ins.rb};
            end
            F_ADDI, F_LW: begin
                r.value = (ins.func == F_ADDI) ? va + imm32 : mem_model[va[MEM_AW-1:0]];
                reg_model[ins.rd] = r.value;
                wslot = {1'b0, ins.rd};
                c1 = {1'b0, ins.ra};
            end
            F_SW: begin
                r.value = vb;
                mem_model[va[MEM_AW-1:0]] = vb;
                wslot = {1'b0, ins.ra};
                c1 = {1'b0, ins.rb};
            end
            F_BEQ: begin
                if (va == vb) begin
                    r.taken = 1'b1;
                    r.next_pos = {1'b0, ins.tgt};
                end
                wslot = {1'b0, ins.ra};
                c1 = {1'b0, ins.rb};
            end
            default: begin
            end
        endcase
        // A bubble touches no counter and cannot be a hazard.
        if (ins.func != F_NOP) begin
            r.hazard = slot_hit(c1) || slot_hit(c2);
            exec_cnt = sat_inc(exec_cnt);
            if (ins.func == F_BEQ)
                branch_cnt = sat_inc(branch_cnt);
            if (r.hazard)
                hazard_cnt = sat_inc(hazard_cnt);
        end
        last_wslot[1] = last_wslot[0];
        last_wslot[0] = wslot;
        r.executed = exec_cnt;
        r.stalls = hazard_cnt;
        r.cyc_fwd = CYC_W'(PIPE_FILL) + CYC_W'(exec_cnt) + CYC_W'(branch_cnt) - 1'b1;
        r.cyc_stall = r.cyc_fwd + CYC_W'(hazard_cnt);
        return r;
    endfunction

    // Long gap-free stretches alternate with random waits.
    function automatic int draw_wait(int idx);
        if ((idx / 96) % 4 == 3 || $urandom_range(0, 2) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    function automatic logic [REG_W-1:0] pick_reg();
        if ($urandom_range(0, 3) == 0)
            return REG_W'($urandom);
        return REG_W'($urandom_range(0, 5));
    endfunction

    task automatic log_mismatch(string what);
        $display("tb: mismatch on result %0d: %s", results_seen, what);
        mismatch_count++;
    endtask

    task automatic issue(instr_row_t ins, int idx);
        exec_result_t exp;
        int           gap;
        gap = fast_mode ? 0 : draw_wait(idx);
        if (gap != 0) begin
            i_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_func = ins.func;
        i_reg_d = ins.rd;
        i_reg_a = ins.ra;
        i_reg_b = ins.rb;
        i_immediate = ins.imm;
        i_target = ins.tgt;
        i_position = ins.pos;
        i_valid = 1'b1;
        do @(posedge i_clk); while (o_stall);
        exp = execute_instr(ins);
        if (ins.lit) begin
            exp.value = ins.lit_value;
            exp.taken = ins.lit_taken;
            exp.next_pos = ins.lit_next;
        end
        pending_results.push_back(exp);
        @(negedge i_clk);
    endtask

    initial begin
        instr_row_t       ins;
        logic [REG_W-1:0] sw_base;
        logic [REG_W-1:0] sat_reg;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_func = F_ADD;
        i_reg_d = '0;
        i_reg_a = '0;
        i_reg_b = '0;
        i_immediate = '0;
        i_target = '0;
        i_position = '0;
        for (int k = 0; k < REG_COUNT; k++)
            reg_model[k] = '0;
        for (int k = 0; k < MEM_WORDS; k++)
            mem_model[k] = '0;
        last_wslot[0] = NO_SLOT;
        last_wslot[1] = NO_SLOT;
        exec_cnt = '0;
        branch_cnt = '0;
        hazard_cnt = '0;
        sw_base = '0;
        repeat (3) @(negedge i_clk);
        i_rst_n = 1'b1;

        for (int k = 0; k < $size(DIRECTED); k++)
            issue(DIRECTED[k], k);

        for (int k = 0; k < RANDOM_ITEMS; k++) begin
            ins = '0;
            ins.func = ($urandom_range(0, 15) == 0) ? F_NOP : FUNC_W'($urandom_range(0, 6));
            ins.rd = pick_reg();
            ins.ra = pick_reg();
            ins.rb = pick_reg();
            case ($urandom_range(0, 3))
                0: ins.imm = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                1: ins.imm = IMM_W'($urandom_range(0, 32) - 16);
                default: ins.imm = IMM_W'($urandom);
            endcase
            ins.tgt = POS_W'($urandom);
            ins.pos = ($urandom_range(0, 3) == 0) ? 10'h3FF : POS_W'($urandom);
            // Loads often reuse the last store base so they read back stored words.
            if (ins.func == F_SW)
                sw_base = ins.ra;
            else if (ins.func == F_LW && $urandom_range(0, 1) == 1)
                ins.ra = sw_base;
            issue(ins, k);
        end

        // Every item is a taken branch that depends on the one before it.
        fast_mode = 1'b1;
        sat_reg = REG_W'($urandom);
        for (int k = 0; k < SAT_ITEMS; k++) begin
            ins = '0;
            ins.func = F_BEQ;
            ins.ra = sat_reg;
            ins.rb = sat_reg;
            ins.tgt = POS_W'($urandom);
            ins.pos = POS_W'($urandom);
            issue(ins, k);
        end
        i_valid = 1'b0;

        while (pending_results.size() != 0)
            @(posedge i_clk);
        repeat (16) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        exec_result_t exp;
        int           hold;
        i_stall = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (fast_mode)
                hold = 0;
            else if (results_seen == HOLD_AT)
                hold = HOLD_CYCLES;
            else
                hold = draw_wait(results_seen + 48);
            if (hold != 0) begin
                i_stall = 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall = 1'b0;
            do @(posedge i_clk); while (!o_valid);
            if (pending_results.size() == 0) begin
                log_mismatch($sformatf("unexpected transaction, value %h", o_result_value));
            end else begin
                exp = pending_results.pop_front();
                if (o_result_value !== exp.value)
                    log_mismatch($sformatf("value %h, expected %h", o_result_value, exp.value));
                if (o_branch_taken !== exp.taken)
                    log_mismatch($sformatf("taken %b, expected %b", o_branch_taken, exp.taken));
                if (o_next_position !== exp.next_pos)
                    log_mismatch($sformatf("next position %0d, expected %0d",
                                           o_next_position, exp.next_pos));
                if (o_hazard !== exp.hazard)
                    log_mismatch($sformatf("hazard %b, expected %b", o_hazard, exp.hazard));
                if (o_executed_total !== exp.executed)
                    log_mismatch($sformatf("executed %0d, expected %0d",
                                           o_executed_total, exp.executed));
                if (o_stall_total !== exp.stalls)
                    log_mismatch($sformatf("stalls %0d, expected %0d",
                                           o_stall_total, exp.stalls));
                if (o_cycles_forwarding !== exp.cyc_fwd)
                    log_mismatch($sformatf("forwarding cycles %0d, expected %0d",
                                           o_cycles_forwarding, exp.cyc_fwd));
                if (o_cycles_stalling !== exp.cyc_stall)
                    log_mismatch($sformatf("stalling cycles %0d, expected %0d",
                                           o_cycles_stalling, exp.cyc_stall));
            end
            results_seen++;
            @(negedge i_clk);
        end
    end

    initial begin
        #5_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

`default_nettype wire

// File: files.f
+incdir+rtl
rtl/mre_pkg.sv
rtl/mre_alu.sv
rtl/mini_risc_execute_with_hazard_count_unit.sv
rtl/mre_checker.sv
tb/sv/testbench.sv
